// File: design/mket_pkg.sv
package mket_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int ENTRY_W   = 29;

	localparam logic [7:0] TRIGGER_LIMIT = 8'd30;

	typedef struct packed {
		logic        enable;
		logic [7:0]  key_code;
		logic [3:0]  kind;
		logic [15:0] operand;
	} map_entry_t;

	typedef enum logic [3:0] {
		SRC_BUTTONS = 4'd0,
		SRC_LTRIG   = 4'd1,
		SRC_RTRIG   = 4'd2,
		SRC_LX_LT   = 4'd3,
		SRC_LX_GT   = 4'd4,
		SRC_LY_GT   = 4'd5,
		SRC_LY_LT   = 4'd6,
		SRC_RX_LT   = 4'd7,
		SRC_RX_GT   = 4'd8,
		SRC_RY_GT   = 4'd9,
		SRC_RY_LT   = 4'd10
	} src_kind_t;

	typedef enum logic [1:0] {
		ST_UP            = 2'd0,
		ST_JUST_PRESSED  = 2'd1,
		ST_HELD          = 2'd2,
		ST_JUST_RELEASED = 2'd3
	} key_state_t;

	typedef struct packed {
		logic [15:0]        pad_buttons;
		logic [7:0]         left_trigger;
		logic [7:0]         right_trigger;
		logic signed [15:0] left_stick_x;
		logic signed [15:0] left_stick_y;
		logic signed [15:0] right_stick_x;
		logic signed [15:0] right_stick_y;
		logic               pad_valid;
		logic [7:0]         kb_pressed_mask;
	} poll_t;

	function automatic key_state_t next_state(key_state_t cur, logic pressed);
		logic down;
		down = (cur == ST_JUST_PRESSED) || (cur == ST_HELD);
		if (pressed) begin
			return down ? ST_HELD : ST_JUST_PRESSED;
		end
		return down ? ST_JUST_RELEASED : ST_UP;
	endfunction

endpackage

// File: design/mket_poll_if.sv
interface mket_poll_if;
	logic               valid;
	logic               ready;
	logic [15:0]        pad_buttons;
	logic [7:0]         left_trigger;
	logic [7:0]         right_trigger;
	logic signed [15:0] left_stick_x;
	logic signed [15:0] left_stick_y;
	logic signed [15:0] right_stick_x;
	logic signed [15:0] right_stick_y;
	logic               pad_valid;
	logic [7:0]         kb_pressed_mask;

	modport source (
		output valid, pad_buttons, left_trigger, right_trigger, left_stick_x,
			left_stick_y, right_stick_x, right_stick_y, pad_valid, kb_pressed_mask,
		input  ready
	);

	modport sink (
		input  valid, pad_buttons, left_trigger, right_trigger, left_stick_x,
			left_stick_y, right_stick_x, right_stick_y, pad_valid, kb_pressed_mask,
		output ready
	);
endinterface

// File: design/mket_result_if.sv
interface mket_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] entry_index;
	logic [7:0] key_code;
	logic [1:0] key_state;
	logic       last_entry;

	modport source (
		output valid, entry_index, key_code, key_state, last_entry,
		input  ready
	);

	modport sink (
		input  valid, entry_index, key_code, key_state, last_entry,
		output ready
	);
endinterface

// File: design/mapped_key_edge_tracker.sv
// Mapped key edge tracker.
// poll (sink): one beat is one controller/keyboard snapshot. It is taken when
//   valid and ready are high at a clock edge; ready is high only while idle.
// result (source): one beat per enabled mapping entry, in index order, with
//   the entry index, its key code, its edge state (up, just pressed, held,
//   just released) and last_entry set on the final beat of the poll.
// APB port: map_entry_0..7 at byte addresses 0x00..0x1C; write only while
//   no poll is in flight. pready is tied high.
// Flow: a poll is first captured, then the mapping entries are walked one per
//   cycle (holding while a result beat stalls) through the shared source
//   compare unit; the first result comes from the first enabled entry.
// A result beat waits in the output register while the receiver stalls; the
//   entry walk holds on an enabled entry until that register frees up.
// Reset clears the mapping table and every edge state to up, and drops
//   any pending result beat.
module mapped_key_edge_tracker #(
	parameter int NUM_KEYS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mket_poll_if.sink                    poll,
	mket_result_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mket_pkg::ADDR_W-1:0]  paddr,
	input  logic [mket_pkg::DATA_W-1:0]  pwdata,
	output logic [mket_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import mket_pkg::*;

	localparam int         SW        = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam logic [2:0] LAST_SLOT = 3'(NUM_KEYS - 1);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	map_entry_t entries [NUM_SLOTS];
	map_entry_t cur_entry;
	poll_t      snap_q;
	poll_t      poll_in;
	state_t     state_q;
	logic [2:0] idx_q;
	logic [2:0] last_q;
	logic [2:0] last_en;
	key_state_t edge_q [NUM_KEYS];
	key_state_t cur_st;
	key_state_t nxt_st;
	logic       pad_active;
	logic       pressed;
	logic       out_free;
	logic       step;
	logic       emit;
	logic       out_valid_q;
	logic [2:0] out_index_q;
	logic [7:0] out_code_q;
	key_state_t out_state_q;
	logic       out_last_q;

	mket_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.entries (entries)
	);

	assign cur_entry = entries[idx_q];

	mket_src_unit u_src (
		.entry  (cur_entry),
		.snap   (snap_q),
		.active (pad_active)
	);

	assign poll_in = '{
		pad_buttons:     poll.pad_buttons,
		left_trigger:    poll.left_trigger,
		right_trigger:   poll.right_trigger,
		left_stick_x:    poll.left_stick_x,
		left_stick_y:    poll.left_stick_y,
		right_stick_x:   poll.right_stick_x,
		right_stick_y:   poll.right_stick_y,
		pad_valid:       poll.pad_valid,
		kb_pressed_mask: poll.kb_pressed_mask
	};

	always_comb begin
		last_en = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (entries[i].enable) begin
				last_en = 3'(i);
			end
		end
	end

	assign pressed  = snap_q.kb_pressed_mask[idx_q] | (snap_q.pad_valid & pad_active);
	assign cur_st   = edge_q[idx_q[SW-1:0]];
	assign nxt_st   = next_state(cur_st, pressed);
	assign out_free = !out_valid_q || result.ready;
	assign step     = (state_q == S_RUN) && (!cur_entry.enable || out_free);
	assign emit     = step && cur_entry.enable;

	assign poll.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_KEYS; i++) begin
				edge_q[i] <= ST_UP;
			end
		end else begin
			out_valid_q <= emit || (out_valid_q && !result.ready);
			unique case (state_q)
				S_IDLE: begin
					if (poll.valid) begin
						idx_q   <= '0;
						last_q  <= last_en;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (step) begin
						edge_q[idx_q[SW-1:0]] <= cur_entry.enable ? nxt_st : ST_UP;
						if (idx_q == LAST_SLOT) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			snap_q <= poll_in;
		end
		if (emit) begin
			out_index_q <= idx_q;
			out_code_q  <= cur_entry.key_code;
			out_state_q <= nxt_st;
			out_last_q  <= (idx_q == last_q);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.entry_index = out_index_q;
	assign result.key_code    = out_code_q;
	assign result.key_state   = out_state_q;
	assign result.last_entry  = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		poll.valid && poll.ready |=> !poll.ready)
		else $error("poll accepted on consecutive cycles");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.entry_index)
			&& $stable(result.key_state) && $stable(result.last_entry))
		else $error("stalled result beat changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.entry_index <= LAST_SLOT)
		else $error("result beat for an entry beyond the table");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result register overwritten while occupied");
endmodule

// File: design/mket_cfg_regs.sv
module mket_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mket_pkg::ADDR_W-1:0]         paddr,
	input  logic [mket_pkg::DATA_W-1:0]         pwdata,
	output logic [mket_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	output mket_pkg::map_entry_t                entries [mket_pkg::NUM_SLOTS]
);
	import mket_pkg::*;

	map_entry_t regs_q [NUM_SLOTS];
	logic [2:0] sel;

	assign sel    = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign prdata = {{(DATA_W-ENTRY_W){1'b0}}, regs_q[sel]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (psel && penable && pwrite) begin
			regs_q[sel] <= map_entry_t'(pwdata[ENTRY_W-1:0]);
		end
	end

	assign entries = regs_q;
endmodule

// File: design/mket_src_unit.sv
module mket_src_unit (
	input  mket_pkg::map_entry_t entry,
	input  mket_pkg::poll_t      snap,
	output logic                 active
);
	import mket_pkg::*;

	logic signed [15:0] thr;
	logic signed [15:0] axis;
	logic               want_lt;
	logic               axis_sel;
	logic               lt;
	logic               gt;

	assign thr = $signed(entry.operand);

	always_comb begin
		axis     = snap.left_stick_x;
		want_lt  = 1'b0;
		axis_sel = 1'b0;
		active   = 1'b0;
		unique case (src_kind_t'(entry.kind))
			SRC_BUTTONS: active = |(snap.pad_buttons & entry.operand);
			SRC_LTRIG:   active = snap.left_trigger > TRIGGER_LIMIT;
			SRC_RTRIG:   active = snap.right_trigger > TRIGGER_LIMIT;
			SRC_LX_LT: begin
				axis = snap.left_stick_x;  want_lt = 1'b1; axis_sel = 1'b1;
			end
			SRC_LX_GT: begin
				axis = snap.left_stick_x;  want_lt = 1'b0; axis_sel = 1'b1;
			end
			SRC_LY_GT: begin
				axis = snap.left_stick_y;  want_lt = 1'b0; axis_sel = 1'b1;
			end
			SRC_LY_LT: begin
				axis = snap.left_stick_y;  want_lt = 1'b1; axis_sel = 1'b1;
			end
			SRC_RX_LT: begin
				axis = snap.right_stick_x; want_lt = 1'b1; axis_sel = 1'b1;
			end
			SRC_RX_GT: begin
				axis = snap.right_stick_x; want_lt = 1'b0; axis_sel = 1'b1;
			end
			SRC_RY_GT: begin
				axis = snap.right_stick_y; want_lt = 1'b0; axis_sel = 1'b1;
			end
			SRC_RY_LT: begin
				axis = snap.right_stick_y; want_lt = 1'b1; axis_sel = 1'b1;
			end
			default: active = 1'b0;
		endcase
		lt = axis < thr;
		gt = axis > thr;
		if (axis_sel) begin
			active = want_lt ? lt : gt;
		end
	end
endmodule
